@@ sv/twls_pkg.sv @@
// Shared types, constants and helper functions for the text window line scroller.
`default_nettype none

package twls_pkg;

  // Screen geometry of the cell store.
  localparam int SCREEN_ROWS = 32;
  localparam int SCREEN_COLS = 128;
  localparam int ROW_AW      = $clog2(SCREEN_ROWS);
  localparam int COL_AW      = $clog2(SCREEN_COLS);
  localparam int ADDR_W      = ROW_AW + COL_AW;
  localparam int MEM_DEPTH   = 2 ** ADDR_W;

  // Row and column sums (window origin plus offset) before the screen check.
  localparam int ROW_SUM_W = 9;
  localparam int COL_SUM_W = 10;
  localparam logic [ROW_SUM_W-1:0] ROW_LIMIT = ROW_SUM_W'(SCREEN_ROWS);
  localparam logic [COL_SUM_W-1:0] COL_LIMIT = COL_SUM_W'(SCREEN_COLS);

  localparam int CODE_W = 21;
  localparam logic [CODE_W-1:0] SPACE_CODE = CODE_W'(32'h20);

  localparam logic [5:0] CURSOR_MAX = 6'd63;
  localparam logic [7:0] COUNT_MAX  = 8'd255;

  // Request opcodes.
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIN_COL    = 2'd0;
  localparam logic [1:0] CFG_WIN_ROW    = 2'd1;
  localparam logic [1:0] CFG_WIN_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_WIN_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // Memory access request from the window sweeper.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CODE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic on_screen(input logic [ROW_SUM_W-1:0] row,
                                     input logic [COL_SUM_W-1:0] col);
    return (row < ROW_LIMIT) && (col < COL_LIMIT);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_SUM_W-1:0] row,
                                                  input logic [COL_SUM_W-1:0] col);
    return {row[ROW_AW-1:0], col[COL_AW-1:0]};
  endfunction

  function automatic logic [5:0] row_adv(input logic [5:0] row);
    return (row < CURSOR_MAX) ? row + 6'd1 : row;
  endfunction

  function automatic logic [5:0] row_dec(input logic [5:0] row);
    return (row != 6'd0) ? row - 6'd1 : row;
  endfunction

endpackage

`default_nettype wire

@@ sv/twls_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module twls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/twls_sweep.sv @@
// Window sweeper: walks the window cell by cell to scroll it up one row or blank it.
`default_nettype none

module twls_sweep (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         blank_all,
  input  wire logic [6:0]                   win_col,
  input  wire logic [4:0]                   win_row,
  input  wire logic [7:0]                   win_width,
  input  wire logic [5:0]                   win_height,
  input  wire logic [twls_pkg::CODE_W-1:0]  rdata,
  output logic                              busy,
  output twls_pkg::ram_req_t                req
);

  import twls_pkg::*;

  logic              active;
  logic              mode_blank;
  logic [5:0]        row_idx;
  logic [7:0]        col_idx;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic              pend_on;
  logic              pend_blank;

  logic [ROW_SUM_W-1:0] dest_row;
  logic [ROW_SUM_W-1:0] src_row;
  logic [COL_SUM_W-1:0] col;
  logic                 last_row;
  logic                 last_col;

  // The source cell one row below is read now and written to the destination
  // in the next cycle, when the registered read data arrives.
  always_comb begin
    dest_row = ROW_SUM_W'(win_row) + ROW_SUM_W'(row_idx);
    src_row  = dest_row + ROW_SUM_W'(1);
    col      = COL_SUM_W'(win_col) + COL_SUM_W'(col_idx);
    last_row = (row_idx == win_height - 6'd1);
    last_col = (col_idx == win_width - 8'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
    end else if (start) begin
      active     <= (win_height != 6'd0) && (win_width != 8'd0);
      mode_blank <= blank_all;
      row_idx    <= 6'd0;
      col_idx    <= 8'd0;
      pend       <= 1'b0;
    end else begin
      pend <= active;
      if (active) begin
        pend_addr  <= cell_addr(dest_row, col);
        pend_on    <= on_screen(dest_row, col);
        pend_blank <= mode_blank || last_row || !on_screen(src_row, col);
        if (last_col) begin
          col_idx <= 8'd0;
          if (last_row) begin
            active <= 1'b0;
          end else begin
            row_idx <= row_idx + 6'd1;
          end
        end else begin
          col_idx <= col_idx + 8'd1;
        end
      end
    end
  end

  always_comb begin
    busy      = active || pend;
    req.we    = pend && pend_on;
    req.waddr = pend_addr;
    req.wdata = pend_blank ? SPACE_CODE : rdata;
    req.raddr = cell_addr(src_row, col);
  end

endmodule

`default_nettype wire

@@ sv/text_window_line_scroller.sv @@
// Top level of the text window line scroller: request control, registers and cell memory.
//
// The block keeps a 32 x 128 character screen, one 21-bit code point per cell, in a
// single synchronous memory, and a rectangular window with a line cursor in it. A
// request is taken at a clock edge where start is high and busy is low. Without a
// scroll, character writes, empty lines and cell reads go from the request edge into
// the decision state, in which the character is written or the read data is picked up.
// A read returns its result as a one-cycle done strobe with cell_code and
// cursor_line in the cycle after that; the receiver cannot stall, so the result must
// be captured on that edge. When a line starts with the cursor at or below the
// window height, the window is first scrolled up by one row, and a clear request
// blanks the window; both walk the window one cell per cycle through the memory's
// single write port. After a scroll the request ends in a finish state, where the
// character is written or the empty line is taken, while a clear goes straight back
// to idle; with a zero width or height there is no walk. Right after reset the whole
// memory is set to space, one cell per cycle, with busy held high; configuration
// writes are taken at any time during that pass. Configuration registers may only be
// written while no request is in progress.
`default_nettype none

module text_window_line_scroller (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   op,
  input  wire logic [twls_pkg::CODE_W-1:0]  char_code,
  input  wire logic                         line_end,
  input  wire logic [4:0]                   read_row,
  input  wire logic [6:0]                   read_col,
  output logic                              done,
  output logic      [twls_pkg::CODE_W-1:0]  cell_code,
  output logic      [5:0]                   cursor_line,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [7:0]                   cfg_data
);

  import twls_pkg::*;

  state_t state;
  state_t state_next;

  // Window registers.
  logic [6:0] win_col;
  logic [4:0] win_row;
  logic [7:0] win_width;
  logic [5:0] win_height;

  // Line cursor and the count of characters in the open line.
  logic [5:0] cursor_row;
  logic [7:0] column_count;

  // The request being worked on.
  logic [1:0]        req_op;
  logic [CODE_W-1:0] req_code;
  logic              req_last;
  logic [4:0]        req_row;
  logic [6:0]        req_col;

  logic [ADDR_W-1:0] init_addr;
  logic              init_last;

  // Memory ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CODE_W-1:0] ram_rdata;

  // Sweeper handshake.
  logic     sweep_start;
  logic     sweep_blank;
  logic     sweep_busy;
  ram_req_t sweep_req;

  // Character write at the cursor, and the line decisions.
  logic [ROW_SUM_W-1:0] char_row;
  logic [COL_SUM_W-1:0] char_col;
  logic                 char_we;
  logic [7:0]           count_inc;
  logic                 char_scroll;
  logic [5:0]           line_row;
  logic                 line_scroll;
  logic                 read_on;

  logic accept;

  always_comb begin
    accept      = start && !busy;
    char_row    = ROW_SUM_W'(win_row) + ROW_SUM_W'(cursor_row);
    char_col    = COL_SUM_W'(win_col) + COL_SUM_W'(column_count);
    char_we     = (column_count < win_width) && on_screen(char_row, char_col);
    count_inc   = (column_count < COUNT_MAX) ? column_count + 8'd1 : column_count;
    // A character that opens a line with the cursor past the window scrolls first.
    char_scroll = (column_count == 8'd0) && (cursor_row >= win_height);
    // An empty line first closes an open line, then starts its own.
    line_row    = (column_count != 8'd0) ? row_adv(cursor_row) : cursor_row;
    line_scroll = (line_row >= win_height);
    read_on     = on_screen(ROW_SUM_W'(req_row), COL_SUM_W'(req_col));
    init_last   = (init_addr == {ADDR_W{1'b1}});
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (init_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (req_op)
          OP_CHAR:  state_next = char_scroll ? ST_SWEEP : ST_IDLE;
          OP_LINE:  state_next = line_scroll ? ST_SWEEP : ST_IDLE;
          OP_CLEAR: state_next = ST_SWEEP;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_SWEEP: begin
        if (!sweep_busy) begin
          state_next = (req_op == OP_CLEAR) ? ST_IDLE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // Outputs of the controller: busy, sweeper start and the memory port steering.
  always_comb begin
    busy        = (state != ST_IDLE);
    sweep_start = 1'b0;
    sweep_blank = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cell_addr(char_row, char_col);
    ram_wdata   = req_code;
    // While idle the read port follows the request ports, so read data is ready
    // in the decision cycle.
    ram_raddr   = cell_addr(ROW_SUM_W'(read_row), COL_SUM_W'(read_col));
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_addr;
        ram_wdata = SPACE_CODE;
      end
      ST_DECIDE: begin
        case (req_op)
          OP_CHAR: begin
            sweep_start = char_scroll;
            ram_we      = !char_scroll && char_we;
          end
          OP_LINE: begin
            sweep_start = line_scroll;
          end
          OP_CLEAR: begin
            sweep_start = 1'b1;
            sweep_blank = 1'b1;
          end
          default: begin
            sweep_start = 1'b0;
          end
        endcase
      end
      ST_SWEEP: begin
        ram_we    = sweep_req.we;
        ram_waddr = sweep_req.waddr;
        ram_wdata = sweep_req.wdata;
        ram_raddr = sweep_req.raddr;
      end
      ST_FINISH: begin
        ram_we = (req_op == OP_CHAR) && char_we;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Registers, cursor and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_col      <= 7'd0;
      win_row      <= 5'd0;
      win_width    <= 8'd128;
      win_height   <= 6'd32;
      cursor_row   <= 6'd0;
      column_count <= 8'd0;
      init_addr    <= '0;
      done         <= 1'b0;
    end else begin
      // The result strobe follows the decision cycle of a read request.
      done <= (state == ST_DECIDE) && (req_op == OP_READ);

      if (cfg_we) begin
        case (cfg_index)
          CFG_WIN_COL:    win_col    <= cfg_data[6:0];
          CFG_WIN_ROW:    win_row    <= cfg_data[4:0];
          CFG_WIN_WIDTH:  win_width  <= cfg_data;
          CFG_WIN_HEIGHT: win_height <= cfg_data[5:0];
          default:        win_col    <= win_col;
        endcase
      end

      if (state == ST_INIT) begin
        init_addr <= init_addr + ADDR_W'(1);
      end

      if (accept) begin
        req_op   <= op;
        req_code <= char_code;
        req_last <= line_end;
        req_row  <= read_row;
        req_col  <= read_col;
      end

      if (state == ST_DECIDE) begin
        case (req_op)
          OP_CHAR: begin
            if (char_scroll) begin
              cursor_row <= row_dec(cursor_row);
            end else if (req_last) begin
              column_count <= 8'd0;
              cursor_row   <= row_adv(cursor_row);
            end else begin
              column_count <= count_inc;
            end
          end
          OP_LINE: begin
            column_count <= 8'd0;
            cursor_row   <= line_scroll ? row_dec(line_row) : row_adv(line_row);
          end
          OP_CLEAR: begin
            column_count <= 8'd0;
            cursor_row   <= 6'd0;
          end
          default: begin
            cell_code   <= read_on ? ram_rdata : SPACE_CODE;
            cursor_line <= cursor_row;
          end
        endcase
      end

      // After a scroll the character is written, or the empty line is taken.
      if (state == ST_FINISH) begin
        if (req_op == OP_CHAR) begin
          if (req_last) begin
            column_count <= 8'd0;
            cursor_row   <= row_adv(cursor_row);
          end else begin
            column_count <= count_inc;
          end
        end else begin
          cursor_row <= row_adv(cursor_row);
        end
      end
    end
  end

  twls_sweep u_sweep (
    .clk        (clk),
    .rst        (rst),
    .start      (sweep_start),
    .blank_all  (sweep_blank),
    .win_col    (win_col),
    .win_row    (win_row),
    .win_width  (win_width),
    .win_height (win_height),
    .rdata      (ram_rdata),
    .busy       (sweep_busy),
    .req        (sweep_req)
  );

  twls_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MEM_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A result only follows the decision cycle of a read request.
  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DECIDE && req_op == OP_READ))
    else $error("result strobe without a read request");

  // The sweeper only runs while the controller waits on it.
  a_sweep_in_state: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> (state == ST_SWEEP))
    else $error("sweeper active outside the sweep state");

  // Nothing writes the cell memory while the block is idle.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("cell memory written while idle");

  // The cursor only moves while a request is being worked on.
  a_cursor_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> $stable(cursor_row))
    else $error("cursor moved without a request");

endmodule

`default_nettype wire

@@ tb/tb_text_window_line_scroller.sv @@
// Self-checking testbench for the text window line scroller: scripted and random requests.
`default_nettype none

module tb_text_window_line_scroller;
  timeunit 1ns;
  timeprecision 1ps;

  import twls_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int MAX_SHOWN    = 10;

  // One cell read result: the code point and the line cursor after the request.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [5:0]        line;
  } cell_read_t;

  // A scripted row is either a window setting or a request. Reads whose answer
  // is obvious carry it typed in; all other rows rely on the shadow screen.
  typedef struct packed {
    logic              is_window;
    logic [1:0]        op;
    logic [CODE_W-1:0] code;
    logic              last;
    logic [4:0]        rr;
    logic [6:0]        rc;
    logic              known;
    cell_read_t        known_val;
    logic [6:0]        wc;
    logic [4:0]        wr;
    logic [7:0]        ww;
    logic [5:0]        wh;
  } script_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        op;
  logic [CODE_W-1:0] char_code;
  logic              line_end;
  logic [4:0]        read_row;
  logic [6:0]        read_col;
  logic              done;
  logic [CODE_W-1:0] cell_code;
  logic [5:0]        cursor_line;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [7:0]        cfg_data;

  // Typed-in expectation that travels with a scripted read request.
  logic              known_valid;
  cell_read_t        known_read;

  // Shadow copy of the screen, the cursor and the window registers.
  logic [CODE_W-1:0] shadow_cells [0:SCREEN_ROWS-1][0:SCREEN_COLS-1];
  logic [5:0]        line_cursor;
  logic [7:0]        line_fill;
  logic [6:0]        wcol;
  logic [4:0]        wrow;
  logic [7:0]        wwidth;
  logic [5:0]        wheight;

  cell_read_t        pending_reads [$];
  script_row_t       script [$];

  int  err_count;
  int  reads_checked;
  int  requests_sent;
  int  window_settings;
  int  cycle_count;
  bit  steady;

  text_window_line_scroller u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .char_code   (char_code),
    .line_end    (line_end),
    .read_row    (read_row),
    .read_col    (read_col),
    .done        (done),
    .cell_code   (cell_code),
    .cursor_line (cursor_line),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow screen. Cells off the 32 x 128 screen read as space and swallow
  // writes, which covers windows that hang over the right or bottom edge.
  // ---------------------------------------------------------------------------
  function automatic logic [CODE_W-1:0] cell_at(input int r, input int c);
    if (r < SCREEN_ROWS && c < SCREEN_COLS) begin
      return shadow_cells[r][c];
    end
    return SPACE_CODE;
  endfunction

  task automatic cell_set(input int r, input int c, input logic [CODE_W-1:0] v);
    if (r < SCREEN_ROWS && c < SCREEN_COLS) begin
      shadow_cells[r][c] = v;
    end
  endtask

  task automatic clear_shadow();
    int r;
    int c;
    for (r = 0; r < SCREEN_ROWS; r++) begin
      for (c = 0; c < SCREEN_COLS; c++) begin
        shadow_cells[r][c] = SPACE_CODE;
      end
    end
    line_cursor = '0;
    line_fill   = '0;
    wcol        = 7'd0;
    wrow        = 5'd0;
    wwidth      = 8'd128;
    wheight     = 6'd32;
  endtask

  task automatic bump_cursor();
    if (line_cursor < 6'd63) begin
      line_cursor = line_cursor + 6'd1;
    end
  endtask

  // Move the window up one row and blank its bottom row. A zero-height window
  // moves no cells, but the cursor still steps back by one.
  task automatic scroll_window_up();
    int i;
    int j;
    if (wheight > 0) begin
      for (i = 0; i + 1 < int'(wheight); i++) begin
        for (j = 0; j < int'(wwidth); j++) begin
          cell_set(int'(wrow) + i, int'(wcol) + j, cell_at(int'(wrow) + i + 1, int'(wcol) + j));
        end
      end
      for (j = 0; j < int'(wwidth); j++) begin
        cell_set(int'(wrow) + int'(wheight) - 1, int'(wcol) + j, SPACE_CODE);
      end
    end
    if (line_cursor != 6'd0) begin
      line_cursor = line_cursor - 6'd1;
    end
  endtask

  task automatic open_line();
    if (line_cursor >= wheight) begin
      scroll_window_up();
    end
  endtask

  task automatic apply_window_reg(input logic [1:0] idx, input logic [7:0] val);
    case (idx)
      CFG_WIN_COL:    wcol    = val[6:0];
      CFG_WIN_ROW:    wrow    = val[4:0];
      CFG_WIN_WIDTH:  wwidth  = val;
      CFG_WIN_HEIGHT: wheight = val[5:0];
      default: ;
    endcase
  endtask

  // Advance the shadow state by one accepted request; only a read yields a result.
  task automatic apply_request(input logic [1:0] o, input logic [CODE_W-1:0] code,
                               input logic last, input logic [4:0] rr,
                               input logic [6:0] rc, output bit yields,
                               output cell_read_t res);
    int i;
    int j;
    yields = 1'b0;
    res    = '0;
    case (o)
      OP_CHAR: begin
        if (line_fill == 8'd0) begin
          open_line();
        end
        // Characters beyond the window width are dropped, but still counted.
        if (line_fill < wwidth) begin
          cell_set(int'(wrow) + int'(line_cursor), int'(wcol) + int'(line_fill), code);
        end
        if (line_fill != 8'd255) begin
          line_fill = line_fill + 8'd1;
        end
        if (last) begin
          line_fill = '0;
          bump_cursor();
        end
      end
      OP_LINE: begin
        // An open line is closed first; the empty line is then a line of its own.
        if (line_fill != 8'd0) begin
          line_fill = '0;
          bump_cursor();
        end
        open_line();
        bump_cursor();
      end
      OP_CLEAR: begin
        line_cursor = '0;
        line_fill   = '0;
        for (i = 0; i < int'(wheight); i++) begin
          for (j = 0; j < int'(wwidth); j++) begin
            cell_set(int'(wrow) + i, int'(wcol) + j, SPACE_CODE);
          end
        end
      end
      default: begin
        yields = 1'b1;
        res    = {cell_at(int'(rr), int'(rc)), line_cursor};
      end
    endcase
  endtask

  task automatic log_failure(input string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, so the values seen
  // are the ones the block takes in. A result is checked before the request
  // accepted on the same edge is predicted, which keeps the order fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    bit         yields;
    cell_read_t res;
    cell_read_t want;
    if (rst) begin
      clear_shadow();
    end else begin
      if (done === 1'b1) begin
        if (pending_reads.size() == 0) begin
          log_failure($sformatf("read result code=%h line=%0d with no read pending",
                                cell_code, cursor_line));
        end else begin
          want = pending_reads.pop_front();
          reads_checked++;
          if (cell_code !== want.code) begin
            log_failure($sformatf("cell_code expected %h, got %h", want.code, cell_code));
          end
          if (cursor_line !== want.line) begin
            log_failure($sformatf("cursor_line expected %0d, got %0d",
                                  want.line, cursor_line));
          end
        end
      end
      if (cfg_we === 1'b1) begin
        apply_window_reg(cfg_index, cfg_data);
      end
      if (start === 1'b1 && busy === 1'b0) begin
        apply_request(op, char_code, line_end, read_row, read_col, yields, res);
        if (yields) begin
          pending_reads.push_back(known_valid ? known_read : res);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. A request is held on the ports until an edge where busy is
  // low; between requests the sender may sit idle, except in steady phases
  // where requests follow back to back.
  // ---------------------------------------------------------------------------
  task automatic issue(input logic [1:0] o, input logic [CODE_W-1:0] code, input logic last,
                       input logic [4:0] rr, input logic [6:0] rc,
                       input logic known, input cell_read_t known_val);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    op          <= o;
    char_code   <= code;
    line_end    <= last;
    read_row    <= rr;
    read_col    <= rc;
    known_valid <= known;
    known_read  <= known_val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    requests_sent++;
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return CODE_W'(32'h10FFFF);
      2, 3, 4: return CODE_W'($urandom_range(32, 126));
      default: return CODE_W'($urandom_range(0, 1114111));
    endcase
  endfunction

  task automatic send_char(input logic [CODE_W-1:0] code, input logic last);
    issue(OP_CHAR, code, last, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
          1'b0, '0);
  endtask

  task automatic send_misc(input logic [1:0] o);
    issue(o, pick_code(), 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
          7'($urandom_range(0, 127)), 1'b0, '0);
  endtask

  // Reads mostly land in or just past the window so that they see written text.
  task automatic random_read();
    logic [4:0] rr;
    logic [6:0] rc;
    if ($urandom_range(0, 2) == 0) begin
      rr = 5'($urandom_range(0, 31));
      rc = 7'($urandom_range(0, 127));
    end else begin
      rr = 5'(int'(wrow) + $urandom_range(0, int'(wheight)));
      rc = 7'(int'(wcol) + $urandom_range(0, int'(wwidth)));
    end
    issue(OP_READ, pick_code(), 1'($urandom_range(0, 1)), rr, rc, 1'b0, '0);
  endtask

  // Registers are only written with the block idle: no read outstanding and
  // busy low, so a scroll or clear that yields no result has also finished.
  task automatic wait_idle();
    start <= 1'b0;
    repeat (3) @(posedge clk);
    while (busy !== 1'b0 || pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [6:0] c, input logic [4:0] r,
                            input logic [7:0] w, input logic [5:0] h);
    wait_idle();
    write_reg(CFG_WIN_COL, {1'b0, c});
    write_reg(CFG_WIN_ROW, {3'b0, r});
    write_reg(CFG_WIN_WIDTH, w);
    write_reg(CFG_WIN_HEIGHT, {2'b0, h});
    cfg_we <= 1'b0;
    window_settings++;
  endtask

  // Mostly well-formed lines of random length with random text, mixed with
  // reads, empty lines, the odd clear, and lines left open on purpose.
  task automatic run_phase(input int n);
    int base;
    int len;
    int maxlen;
    int k;
    int pick;
    bit leave_open;
    base = requests_sent;
    while (requests_sent - base < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        maxlen = int'(wwidth) + 3;
        if (maxlen > 40) begin
          maxlen = 40;
        end
        len        = $urandom_range(1, maxlen);
        leave_open = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 6) == 0) begin
            random_read();
          end
          send_char(pick_code(), (k == len - 1) && !leave_open);
        end
      end else if (pick < 78) begin
        random_read();
      end else if (pick < 94) begin
        send_misc(OP_LINE);
      end else begin
        send_misc(OP_CLEAR);
      end
    end
  endtask

  function automatic script_row_t row_req(input logic [1:0] o, input logic [CODE_W-1:0] code,
                                          input logic last, input logic [4:0] rr,
                                          input logic [6:0] rc);
    script_row_t s;
    s      = '0;
    s.op   = o;
    s.code = code;
    s.last = last;
    s.rr   = rr;
    s.rc   = rc;
    return s;
  endfunction

  function automatic script_row_t row_known(input logic [4:0] rr, input logic [6:0] rc,
                                            input logic [CODE_W-1:0] code,
                                            input logic [5:0] line);
    script_row_t s;
    s           = row_req(OP_READ, '0, 1'b0, rr, rc);
    s.known     = 1'b1;
    s.known_val = {code, line};
    return s;
  endfunction

  function automatic script_row_t row_win(input logic [6:0] c, input logic [4:0] r,
                                          input logic [7:0] w, input logic [5:0] h);
    script_row_t s;
    s           = '0;
    s.is_window = 1'b1;
    s.wc        = c;
    s.wr        = r;
    s.ww        = w;
    s.wh        = h;
    return s;
  endfunction

  // Timeout guard.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int k;
    int phase;
    int len;
    int shape;
    int scripted;
    err_count       = 0;
    reads_checked   = 0;
    requests_sent   = 0;
    window_settings = 0;
    steady          = 1'b0;

    rst         <= 1'b1;
    start       <= 1'b0;
    op          <= OP_CHAR;
    char_code   <= '0;
    line_end    <= 1'b0;
    read_row    <= '0;
    read_col    <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_WIN_COL;
    cfg_data    <= '0;
    known_valid <= 1'b0;
    known_read  <= '0;

    // Scripted part. It starts on the reset window (full screen), where the
    // screen is all spaces and the cursor is at the top.
    script.push_back(row_known(5'd0, 7'd0, SPACE_CODE, 6'd0));
    script.push_back(row_known(5'd31, 7'd127, SPACE_CODE, 6'd0));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h10FFFF), 1'b0, 5'd0, 7'd0));
    script.push_back(row_req(OP_CHAR, '0, 1'b1, 5'd31, 7'd127));
    script.push_back(row_known(5'd0, 7'd0, CODE_W'(32'h10FFFF), 6'd1));
    script.push_back(row_known(5'd0, 7'd1, '0, 6'd1));
    // An empty line while a line is open closes that line first.
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h41), 1'b0, 5'd0, 7'd0));
    script.push_back(row_req(OP_LINE, '0, 1'b0, 5'd0, 7'd0));
    script.push_back(row_known(5'd1, 7'd0, CODE_W'(32'h41), 6'd3));
    script.push_back(row_req(OP_CLEAR, '0, 1'b0, 5'd0, 7'd0));
    script.push_back(row_known(5'd0, 7'd0, SPACE_CODE, 6'd0));
    // A small window in the bottom right corner: the line runs off the screen
    // and then past the window width, and the third line forces a scroll.
    script.push_back(row_win(7'd126, 5'd30, 8'd4, 6'd2));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h61), 1'b0, 5'd0, 7'd0));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h62), 1'b0, 5'd0, 7'd0));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h63), 1'b0, 5'd0, 7'd0));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h64), 1'b0, 5'd0, 7'd0));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h65), 1'b1, 5'd0, 7'd0));
    script.push_back(row_req(OP_LINE, '0, 1'b0, 5'd0, 7'd0));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h66), 1'b1, 5'd0, 7'd0));
    script.push_back(row_req(OP_READ, '0, 1'b0, 5'd30, 7'd126));
    script.push_back(row_req(OP_READ, '0, 1'b0, 5'd31, 7'd126));
    // The window shrinks under the cursor: one scroll steps it back by one
    // only, and the line lands below the window.
    script.push_back(row_win(7'd126, 5'd30, 8'd3, 6'd1));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h67), 1'b1, 5'd0, 7'd0));
    script.push_back(row_req(OP_READ, '0, 1'b0, 5'd31, 7'd126));
    // A window of zero width and height takes no text but still scrolls the cursor.
    script.push_back(row_win(7'd0, 5'd0, 8'd0, 6'd0));
    script.push_back(row_req(OP_CHAR, CODE_W'(32'h68), 1'b1, 5'd0, 7'd0));
    script.push_back(row_req(OP_LINE, '0, 1'b0, 5'd0, 7'd0));
    script.push_back(row_req(OP_READ, '0, 1'b0, 5'd31, 7'd126));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      if (script[k].is_window) begin
        set_window(script[k].wc, script[k].wr, script[k].ww, script[k].wh);
      end else begin
        issue(script[k].op, script[k].code, script[k].last, script[k].rr, script[k].rc,
              script[k].known, script[k].known_val);
      end
    end
    scripted = requests_sent;

    // Random part, one window setting per phase. Large windows make every
    // scroll and clear walk thousands of cells, so they get short phases and
    // most phases use small windows placed anywhere on the screen.
    phase = 0;
    while (requests_sent - scripted < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      len    = $urandom_range(50, 100);
      case (phase)
        0: begin
          set_window(7'd0, 5'd0, 8'd128, 6'd32);
          len = 15;
        end
        1: set_window(7'd127, 5'd31, 8'd1, 6'd1);
        2: set_window(7'd0, 5'd30, 8'd128, 6'd2);
        3: set_window(7'd127, 5'd0, 8'd1, 6'd32);
        4: begin
          set_window(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)), 8'd0,
                     6'($urandom_range(0, 6)));
          len = 30;
        end
        5: begin
          // One very long line drives the character count to its ceiling.
          set_window(7'd3, 5'd5, 8'd8, 6'd3);
          for (k = 0; k < 300; k++) begin
            send_char(pick_code(), k == 299);
          end
        end
        6: set_window(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                      8'($urandom_range(1, 12)), 6'd0);
        default: begin
          shape = $urandom_range(0, 4);
          if (shape == 0) begin
            set_window(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                       8'($urandom_range(1, 3)), 6'($urandom_range(8, 32)));
          end else if (shape == 1) begin
            set_window(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                       8'($urandom_range(32, 128)), 6'($urandom_range(1, 2)));
          end else begin
            set_window(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                       8'($urandom_range(1, 12)), 6'($urandom_range(1, 6)));
          end
        end
      endcase
      run_phase(len);
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    err_count += pending_reads.size();

    $display("Sent %0d requests (%0d scripted) over %0d window settings in %0d cycles.",
             requests_sent, scripted, window_settings, cycle_count);
    $display("Compared %0d cell reads against the shadow screen.", reads_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
